// File: rtl/core/sync_job_coalescing_scheduler_core_defines.svh
`ifndef SYNC_JOB_COALESCING_SCHEDULER_CORE_DEFINES_SVH
`define SYNC_JOB_COALESCING_SCHEDULER_CORE_DEFINES_SVH

// same-cycle implication, disabled in reset
`define SJCS_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, disabled in reset
`define SJCS_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// File: rtl/core/sjcs_pkg.sv
package sjcs_pkg;

	localparam int unsigned IdW = 53;

	localparam logic [2:0] KIND_SYNC     = 3'd0;
	localparam logic [2:0] KIND_DOWNLOAD = 3'd1;
	localparam logic [2:0] KIND_FINISHED = 3'd2;
	localparam logic [2:0] KIND_ERROR    = 3'd3;
	localparam logic [2:0] KIND_CANCEL   = 3'd4;

	localparam logic [1:0] MODE_SEND   = 2'd0;
	localparam logic [1:0] MODE_NO_ATT = 2'd1;
	localparam logic [1:0] MODE_ALL    = 2'd2;

	typedef struct packed {
		logic [2:0]     kind;
		logic [1:0]     sync_mode;
		logic [IdW-1:0] message_id;
	} in_t;

	typedef struct packed {
		logic           job_start;
		logic           job_is_sync;
		logic [1:0]     job_mode;
		logic [IdW-1:0] job_message_id;
		logic           all_done;
		logic           full_sync_done;
		logic           busy_res;
		logic           queue_overflow;
	} out_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_EXEC,
		ST_SEARCH,
		ST_APPEND,
		ST_DISP_RD,
		ST_DISP,
		ST_FINISH
	} state_t;

	typedef struct packed {
		logic capture;
		logic exec;
		logic scan;
		logic append;
		logic disp;
		logic load;
	} cmd_t;

	typedef struct packed {
		logic dl_search;
		logic do_dispatch;
		logic scan_done;
		logic out_free;
	} status_t;

endpackage

// File: rtl/core/sjcs_ctrl.sv
module sjcs_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  sjcs_pkg::status_t status,
	output sjcs_pkg::cmd_t    cmd
);

	sjcs_pkg::state_t state_q;
	sjcs_pkg::state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= sjcs_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			sjcs_pkg::ST_IDLE: begin
				if (in_valid) state_d = sjcs_pkg::ST_EXEC;
			end
			sjcs_pkg::ST_EXEC: begin
				if (status.dl_search) state_d = sjcs_pkg::ST_SEARCH;
				else if (status.do_dispatch) state_d = sjcs_pkg::ST_DISP_RD;
				else state_d = sjcs_pkg::ST_FINISH;
			end
			sjcs_pkg::ST_SEARCH: begin
				if (status.scan_done) state_d = sjcs_pkg::ST_APPEND;
			end
			sjcs_pkg::ST_APPEND:  state_d = sjcs_pkg::ST_DISP_RD;
			sjcs_pkg::ST_DISP_RD: state_d = sjcs_pkg::ST_DISP;
			sjcs_pkg::ST_DISP:    state_d = sjcs_pkg::ST_FINISH;
			sjcs_pkg::ST_FINISH: begin
				if (status.out_free) state_d = sjcs_pkg::ST_IDLE;
			end
			default: state_d = sjcs_pkg::ST_IDLE;
		endcase
	end

	always_comb begin
		cmd      = '0;
		in_ready = 1'b0;
		case (state_q)
			sjcs_pkg::ST_IDLE: begin
				in_ready    = 1'b1;
				cmd.capture = in_valid;
			end
			sjcs_pkg::ST_EXEC:   cmd.exec = 1'b1;
			sjcs_pkg::ST_SEARCH: cmd.scan = 1'b1;
			sjcs_pkg::ST_APPEND: cmd.append = 1'b1;
			sjcs_pkg::ST_DISP:   cmd.disp = 1'b1;
			sjcs_pkg::ST_FINISH: cmd.load = status.out_free;
			default: ;
		endcase
	end

endmodule

// File: rtl/core/sjcs_dp.sv
`include "sync_job_coalescing_scheduler_core_defines.svh"

module sjcs_dp #(
	parameter int unsigned QUEUE_DEPTH = 16,
	parameter int unsigned ID_BITS     = 53
) (
	input  logic              clk,
	input  logic              arst_n,
	input  sjcs_pkg::in_t     in_data,
	input  sjcs_pkg::cmd_t    cmd,
	output sjcs_pkg::status_t status,
	output logic              out_valid,
	input  logic              out_ready,
	output sjcs_pkg::out_t    out_data
);

	localparam int unsigned StoreBits = (ID_BITS < sjcs_pkg::IdW) ? ID_BITS : sjcs_pkg::IdW;
	localparam int unsigned AddrW     = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int unsigned CntW      = $clog2(QUEUE_DEPTH + 1);
	localparam int unsigned SumW      = ((AddrW > CntW) ? AddrW : CntW) + 1;
	localparam logic [CntW-1:0] DepthC = CntW'(QUEUE_DEPTH);

	logic [StoreBits-1:0] mem [QUEUE_DEPTH];
	logic [StoreBits-1:0] rd_data_q;
	logic [AddrW-1:0]     rd_addr;
	logic [AddrW-1:0]     wr_addr;
	logic                 wr_en;

	sjcs_pkg::in_t        item_q;
	logic [StoreBits-1:0] id_q;

	logic             running_q;
	logic             pend_valid_q;
	logic [1:0]       pend_mode_q;
	logic             last_valid_q;
	logic [1:0]       last_mode_q;
	logic [AddrW-1:0] head_q;
	logic [CntW-1:0]  count_q;
	logic [CntW-1:0]  scan_idx_q;
	logic             scan_issued_q;
	logic             found_q;
	logic             out_valid_q;

	logic                 start_q;
	logic                 is_sync_q;
	logic [1:0]           mode_q;
	logic [StoreBits-1:0] job_id_q;
	logic                 all_done_q;
	logic                 fsd_q;
	logic                 ovf_q;
	sjcs_pkg::out_t       out_q;

	logic all_pending;
	logic can_issue;

	function automatic logic [AddrW-1:0] slot(input logic [AddrW-1:0] base,
		input logic [CntW-1:0] off);
		logic [SumW-1:0] s;
		s = SumW'(base) + SumW'(off);
		if (s >= SumW'(QUEUE_DEPTH)) s = s - SumW'(QUEUE_DEPTH);
		return s[AddrW-1:0];
	endfunction

	assign id_q        = StoreBits'(item_q.message_id);
	assign all_pending = pend_valid_q && (pend_mode_q == sjcs_pkg::MODE_ALL);
	assign can_issue   = scan_idx_q < count_q;

	assign status.dl_search   = (item_q.kind == sjcs_pkg::KIND_DOWNLOAD) && !all_pending;
	assign status.do_dispatch = (item_q.kind == sjcs_pkg::KIND_SYNC) ||
		(item_q.kind == sjcs_pkg::KIND_DOWNLOAD) || (item_q.kind == sjcs_pkg::KIND_FINISHED);
	assign status.scan_done   = !scan_issued_q && !can_issue;
	assign status.out_free    = !out_valid_q || out_ready;

	assign rd_addr = cmd.scan ? slot(head_q, scan_idx_q) : head_q;
	assign wr_addr = slot(head_q, count_q);
	assign wr_en   = cmd.append && !found_q && (count_q < DepthC);

	always_ff @(posedge clk) begin
		if (wr_en) mem[wr_addr] <= id_q;
		rd_data_q <= mem[rd_addr];
	end

	always_ff @(posedge clk) begin
		if (cmd.capture) item_q <= in_data;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			running_q     <= 1'b0;
			pend_valid_q  <= 1'b0;
			pend_mode_q   <= sjcs_pkg::MODE_SEND;
			last_valid_q  <= 1'b0;
			last_mode_q   <= sjcs_pkg::MODE_SEND;
			head_q        <= '0;
			count_q       <= '0;
			scan_idx_q    <= '0;
			scan_issued_q <= 1'b0;
			found_q       <= 1'b0;
			out_valid_q   <= 1'b0;
		end else begin
			if (cmd.exec) begin
				scan_idx_q    <= '0;
				scan_issued_q <= 1'b0;
				found_q       <= 1'b0;
				case (item_q.kind)
					sjcs_pkg::KIND_SYNC: begin
						case (item_q.sync_mode)
							sjcs_pkg::MODE_SEND: begin
								if (!pend_valid_q) begin
									pend_valid_q <= 1'b1;
									pend_mode_q  <= sjcs_pkg::MODE_SEND;
								end
							end
							sjcs_pkg::MODE_NO_ATT: begin
								if (!all_pending) begin
									pend_valid_q <= 1'b1;
									pend_mode_q  <= sjcs_pkg::MODE_NO_ATT;
								end
							end
							sjcs_pkg::MODE_ALL: begin
								pend_valid_q <= 1'b1;
								pend_mode_q  <= sjcs_pkg::MODE_ALL;
								head_q       <= '0;
								count_q      <= '0;
							end
							default: ;
						endcase
					end
					sjcs_pkg::KIND_FINISHED: running_q <= 1'b0;
					sjcs_pkg::KIND_ERROR:    running_q <= 1'b0;
					sjcs_pkg::KIND_CANCEL: begin
						head_q       <= '0;
						count_q      <= '0;
						pend_valid_q <= 1'b0;
						running_q    <= 1'b0;
					end
					default: ;
				endcase
			end
			if (cmd.scan) begin
				scan_issued_q <= can_issue;
				if (can_issue) scan_idx_q <= scan_idx_q + 1'b1;
				if (scan_issued_q && (rd_data_q == id_q)) found_q <= 1'b1;
			end
			if (wr_en) count_q <= count_q + 1'b1;
			if (cmd.disp && !running_q) begin
				if (count_q != '0) begin
					head_q       <= slot(head_q, CntW'(1));
					count_q      <= count_q - 1'b1;
					running_q    <= 1'b1;
					last_valid_q <= 1'b0;
				end else if (pend_valid_q) begin
					running_q    <= 1'b1;
					last_valid_q <= 1'b1;
					last_mode_q  <= pend_mode_q;
					pend_valid_q <= 1'b0;
				end
			end
			if (cmd.load) out_valid_q <= 1'b1;
			else if (out_ready) out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			start_q    <= 1'b0;
			is_sync_q  <= 1'b0;
			mode_q     <= sjcs_pkg::MODE_SEND;
			job_id_q   <= '0;
			all_done_q <= 1'b0;
			fsd_q      <= 1'b0;
			ovf_q      <= 1'b0;
		end
		if (cmd.exec && (item_q.kind == sjcs_pkg::KIND_FINISHED)) begin
			fsd_q <= last_valid_q && ((last_mode_q == sjcs_pkg::MODE_NO_ATT) ||
				(last_mode_q == sjcs_pkg::MODE_ALL));
		end
		if (cmd.append && !found_q && (count_q >= DepthC)) ovf_q <= 1'b1;
		if (cmd.disp && !running_q) begin
			if (count_q != '0) begin
				start_q  <= 1'b1;
				job_id_q <= rd_data_q;
			end else if (pend_valid_q) begin
				start_q   <= 1'b1;
				is_sync_q <= 1'b1;
				mode_q    <= pend_mode_q;
			end else begin
				all_done_q <= 1'b1;
			end
		end
		if (cmd.load) begin
			out_q.job_start      <= start_q;
			out_q.job_is_sync    <= is_sync_q;
			out_q.job_mode       <= mode_q;
			out_q.job_message_id <= sjcs_pkg::IdW'(job_id_q);
			out_q.all_done       <= all_done_q;
			out_q.full_sync_done <= fsd_q;
			out_q.busy_res       <= (count_q != '0) || pend_valid_q || running_q;
			out_q.queue_overflow <= ovf_q;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	`SJCS_ASSERT_NOW(a_count_bound, clk, arst_n, 1'b1, count_q <= DepthC, "fifo count over depth")
	`SJCS_ASSERT_NOW(a_head_bound, clk, arst_n, 1'b1, SumW'(head_q) < SumW'(QUEUE_DEPTH), "head out of range")
	`SJCS_ASSERT_NEXT(a_pop_starts, clk, arst_n, cmd.disp && !running_q && (count_q != '0), running_q && !last_valid_q && start_q && !is_sync_q, "download dispatch failed")
	`SJCS_ASSERT_NEXT(a_push_count, clk, arst_n, wr_en, count_q == $past(count_q) + 1'b1, "append did not grow fifo")

endmodule

// File: rtl/core/sync_job_coalescing_scheduler_core.sv
// Coalescing job scheduler for a single worker: one pending sync slot plus a FIFO of download
// ids held in a single-port-write, registered-read memory. One transaction in gives exactly one
// transaction out. Items are processed one at a time: error, cancel and unused kinds go from
// execute straight to finish; sync and finished pass through dispatch read and dispatch.
// A download does the same while an everything sync is pending; otherwise it first runs the
// duplicate scan, which reads one memory entry per cycle over the queued ids, then appends.
// The next item is accepted while a result still waits in the output register; an item only
// stalls at its end while the previous result is still unread.
module sync_job_coalescing_scheduler_core #(
	parameter int unsigned QUEUE_DEPTH = 16,
	parameter int unsigned ID_BITS     = 53
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           in_valid,
	output logic           in_ready,
	input  sjcs_pkg::in_t  in_data,
	output logic           out_valid,
	input  logic           out_ready,
	output sjcs_pkg::out_t out_data
);

	sjcs_pkg::cmd_t    cmd;
	sjcs_pkg::status_t status;

	sjcs_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.status   (status),
		.cmd      (cmd)
	);

	sjcs_dp #(
		.QUEUE_DEPTH (QUEUE_DEPTH),
		.ID_BITS     (ID_BITS)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_data   (in_data),
		.cmd       (cmd),
		.status    (status),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data)
	);

endmodule

// File: tb/sync_job_sched_monitor.sv
`timescale 1ns / 100ps

module sync_job_sched_monitor (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           in_valid,
	input  logic           in_ready,
	input  sjcs_pkg::in_t  in_data,
	input  logic           out_valid,
	input  logic           out_ready,
	input  sjcs_pkg::out_t out_data,
	output int             errors,
	output int             outstanding
);
	import sjcs_pkg::*;

	localparam int Depth = 16;
	localparam int ExpDepth = 64;

	logic           running;
	logic           pend_valid;
	logic [1:0]     pend_mode;
	logic           last_valid;
	logic [1:0]     last_mode;
	logic [IdW-1:0] ids [Depth];
	logic [3:0]     head;
	int             count;

	out_t exp_buf [ExpDepth];
	int   exp_rd;
	int   exp_wr;
	out_t want;

	function automatic out_t dispatch_next(out_t r);
		out_t q;
		q = r;
		if (!running) begin
			if (count > 0) begin
				q.job_start = 1'b1;
				q.job_is_sync = 1'b0;
				q.job_mode = MODE_SEND;
				q.job_message_id = ids[head];
				head = head + 4'd1;
				count--;
				running = 1'b1;
				last_valid = 1'b0;
			end else if (pend_valid) begin
				q.job_start = 1'b1;
				q.job_is_sync = 1'b1;
				q.job_mode = pend_mode;
				q.job_message_id = '0;
				running = 1'b1;
				last_valid = 1'b1;
				last_mode = pend_mode;
				pend_valid = 1'b0;
			end else begin
				q.all_done = 1'b1;
			end
		end
		return q;
	endfunction

	function automatic out_t schedule_step(in_t t);
		out_t r;
		logic dup;
		r = '0;
		case (t.kind)
			KIND_SYNC: begin
				case (t.sync_mode)
					MODE_SEND: begin
						if (!pend_valid) begin
							pend_valid = 1'b1;
							pend_mode = MODE_SEND;
						end
					end
					MODE_NO_ATT: begin
						if (!(pend_valid && pend_mode == MODE_ALL)) begin
							pend_valid = 1'b1;
							pend_mode = MODE_NO_ATT;
						end
					end
					MODE_ALL: begin
						pend_valid = 1'b1;
						pend_mode = MODE_ALL;
						head = '0;
						count = 0;
					end
					default: ;
				endcase
				r = dispatch_next(r);
			end
			KIND_DOWNLOAD: begin
				if (!(pend_valid && pend_mode == MODE_ALL)) begin
					dup = 1'b0;
					for (int i = 0; i < count; i++)
						if (ids[head + 4'(i)] == t.message_id)
							dup = 1'b1;
					if (!dup) begin
						if (count >= Depth) begin
							r.queue_overflow = 1'b1;
						end else begin
							ids[head + 4'(count)] = t.message_id;
							count++;
						end
					end
				end
				r = dispatch_next(r);
			end
			KIND_FINISHED: begin
				r.full_sync_done = last_valid && (last_mode == MODE_NO_ATT || last_mode == MODE_ALL);
				running = 1'b0;
				r = dispatch_next(r);
			end
			KIND_ERROR: begin
				running = 1'b0;
			end
			KIND_CANCEL: begin
				head = '0;
				count = 0;
				pend_valid = 1'b0;
				running = 1'b0;
			end
			default: ;
		endcase
		r.busy_res = (count > 0) || pend_valid || running;
		return r;
	endfunction

	task automatic field_check(string name, logic [63:0] e, logic [63:0] a);
		if (a !== e) begin
			errors++;
			$display("%0t: %s mismatch, expected %h, actual %h", $time, name, e, a);
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			running = 1'b0;
			pend_valid = 1'b0;
			pend_mode = MODE_SEND;
			last_valid = 1'b0;
			last_mode = MODE_SEND;
			head = '0;
			count = 0;
			errors = 0;
			exp_rd = 0;
			exp_wr = 0;
		end else begin
			if (out_valid && out_ready) begin
				if (exp_wr == exp_rd) begin
					errors++;
					$display("%0t: unexpected transaction, expected none, actual %h",
						$time, out_data);
				end else begin
					want = exp_buf[exp_rd % ExpDepth];
					exp_rd++;
					field_check("job_start", want.job_start, out_data.job_start);
					field_check("job_is_sync", want.job_is_sync, out_data.job_is_sync);
					field_check("job_mode", want.job_mode, out_data.job_mode);
					field_check("job_message_id", want.job_message_id, out_data.job_message_id);
					field_check("all_done", want.all_done, out_data.all_done);
					field_check("full_sync_done", want.full_sync_done, out_data.full_sync_done);
					field_check("busy_res", want.busy_res, out_data.busy_res);
					field_check("queue_overflow", want.queue_overflow, out_data.queue_overflow);
				end
			end
			if (in_valid && in_ready) begin
				if (exp_wr - exp_rd >= ExpDepth) begin
					errors++;
					$display("%0t: too many open transactions, expected at most %0d, actual %0d",
						$time, ExpDepth, exp_wr - exp_rd + 1);
				end
				exp_buf[exp_wr % ExpDepth] = schedule_step(in_data);
				exp_wr++;
			end
		end
		outstanding = exp_wr - exp_rd;
	end

endmodule

// File: tb/sync_job_coalescing_scheduler_core_tb.sv
`timescale 1ns / 100ps

module sync_job_coalescing_scheduler_core_tb;
	import sjcs_pkg::*;

	localparam int ItemTarget = 2000;
	localparam int StallLimit = 4000;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_ready;
	in_t  in_data = '0;
	logic out_valid;
	logic out_ready = 1'b0;
	out_t out_data;

	int errors;
	int outstanding;
	bit calm;
	int profile;

	sync_job_coalescing_scheduler_core uut (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.in_data  (in_data),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_data (out_data)
	);

	sync_job_sched_monitor watch (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.in_data    (in_data),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.out_data   (out_data),
		.errors     (errors),
		.outstanding(outstanding)
	);

	initial forever #1 clk = ~clk;

	function automatic int idle_len();
		int r;
		r = $urandom_range(0, 99);
		if (calm || r < 40)
			return 0;
		if (r < 85)
			return $urandom_range(1, 3);
		if (r < 97)
			return $urandom_range(4, 10);
		return $urandom_range(20, 60);
	endfunction

	function automatic in_t job_item(logic [2:0] kind, logic [1:0] mode, logic [IdW-1:0] id);
		in_t t;
		t.kind = kind;
		t.sync_mode = mode;
		t.message_id = id;
		return t;
	endfunction

	function automatic logic [IdW-1:0] pick_id();
		int r;
		logic [63:0] w;
		r = $urandom_range(0, 99);
		w = {$urandom(), $urandom()};
		if (r < 65)
			return IdW'($urandom_range(0, 24));
		if (r < 75)
			return {IdW{1'b1}} - IdW'($urandom_range(0, 3));
		return w[IdW-1:0];
	endfunction

	function automatic in_t rand_item();
		in_t t;
		int r;
		t.sync_mode = ($urandom_range(0, 19) == 0) ? 2'd3 : 2'($urandom_range(0, 2));
		t.message_id = pick_id();
		r = $urandom_range(0, 99);
		if (profile == 1) begin
			if (r < 85)      t.kind = KIND_DOWNLOAD;
			else if (r < 93) t.kind = KIND_FINISHED;
			else if (r < 96) t.kind = KIND_SYNC;
			else if (r < 97) t.kind = KIND_ERROR;
			else if (r < 98) t.kind = KIND_CANCEL;
			else             t.kind = 3'($urandom_range(5, 7));
		end else begin
			if (r < 25)      t.kind = KIND_SYNC;
			else if (r < 58) t.kind = KIND_DOWNLOAD;
			else if (r < 90) t.kind = KIND_FINISHED;
			else if (r < 94) t.kind = KIND_ERROR;
			else if (r < 97) t.kind = KIND_CANCEL;
			else             t.kind = 3'($urandom_range(5, 7));
		end
		return t;
	endfunction

	task automatic send(in_t t);
		int gap;
		gap = idle_len();
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		in_data <= t;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
	endtask

	initial begin : drain
		int n;
		wait (arst_n);
		@(posedge clk);
		forever begin
			n = idle_len();
			if (n > 0) begin
				out_ready <= 1'b0;
				repeat (n) @(posedge clk);
			end
			out_ready <= 1'b1;
			repeat ($urandom_range(1, 12)) @(posedge clk);
		end
	end

	initial begin : watchdog
		int quiet;
		quiet = 0;
		wait (arst_n);
		while (quiet < StallLimit) begin
			@(posedge clk);
			if ((in_valid && in_ready) || (out_valid && out_ready))
				quiet = 0;
			else
				quiet++;
		end
		$display("sync_job_coalescing_scheduler_core_tb: FAIL");
		$finish;
	end

	initial begin : stimulus
		int sent;
		in_t t;
		calm = 1'b0;
		profile = 0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// fill the download queue behind a running job, then duplicate and overflow
		send(job_item(KIND_DOWNLOAD, MODE_SEND, '0));
		for (int i = 1; i <= 16; i++)
			send(job_item(KIND_DOWNLOAD, MODE_SEND, (i == 16) ? {IdW{1'b1}} : IdW'(i)));
		send(job_item(KIND_DOWNLOAD, MODE_SEND, IdW'(1)));
		send(job_item(KIND_DOWNLOAD, MODE_SEND, IdW'(99)));
		send(job_item(KIND_CANCEL, MODE_SEND, '0));
		// coalescing: everything wins, blocks downloads, others ignored
		send(job_item(KIND_SYNC, MODE_NO_ATT, '0));
		send(job_item(KIND_SYNC, MODE_ALL, '0));
		send(job_item(KIND_DOWNLOAD, MODE_SEND, IdW'(7)));
		send(job_item(KIND_SYNC, 2'd3, '0));
		send(job_item(KIND_SYNC, MODE_SEND, '0));
		send(job_item(KIND_ERROR, MODE_SEND, '0));
		send(job_item(KIND_FINISHED, MODE_SEND, '0));
		send(job_item(KIND_FINISHED, MODE_SEND, '0));
		send(job_item(KIND_FINISHED, MODE_SEND, '0));
		send(job_item(3'd7, 2'd3, {IdW{1'b1}}));

		sent = 0;
		while (sent < ItemTarget) begin
			if ($urandom_range(0, 79) == 0) begin
				profile = ($urandom_range(0, 3) == 0) ? 1 : 0;
				calm = ($urandom_range(0, 4) == 0);
			end
			t = rand_item();
			send(t);
			if (t.kind <= KIND_CANCEL)
				sent++;
		end
		in_valid <= 1'b0;

		@(negedge clk);
		while (outstanding != 0) @(negedge clk);
		repeat (40) @(posedge clk);
		@(negedge clk);
		if (errors == 0 && outstanding == 0)
			$display("sync_job_coalescing_scheduler_core_tb: PASS");
		else
			$display("sync_job_coalescing_scheduler_core_tb: FAIL");
		$finish;
	end

endmodule

// File: filelist.f
+incdir+rtl/core
rtl/core/sjcs_pkg.sv
rtl/core/sjcs_ctrl.sv
rtl/core/sjcs_dp.sv
rtl/core/sync_job_coalescing_scheduler_core.sv
tb/sync_job_sched_monitor.sv
tb/sync_job_coalescing_scheduler_core_tb.sv
